// ===== rtl/core/cubic_bspline_evaluator_unit_macros.svh =====
// Assertion macros for the cubic B-spline evaluator
`ifndef CUBIC_BSPLINE_EVALUATOR_UNIT_MACROS_SVH
`define CUBIC_BSPLINE_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBSPL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CBSPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cbspl_pkg.sv =====
// Types, widths and constants for the cubic B-spline evaluator
`timescale 1ns / 1ps

package cbspl_pkg;

    localparam int MAX_POINTS = 256;
    localparam int COORD_W    = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FRAC_W     = 16;
    localparam int U_W        = IDX_W + FRAC_W;

    localparam int AXES  = 3;
    localparam int TAPS  = 4;
    localparam int KINDS = 3;

    localparam int KIND_POS = 0;
    localparam int KIND_VEL = 1;
    localparam int KIND_ACC = 2;

    // control points are spread over four banks so all points of a segment read in the same cycle
    localparam int BANKS      = TAPS;
    localparam int BANK_SEL_W = $clog2(BANKS);
    localparam int BANK_DEPTH = MAX_POINTS / BANKS;
    localparam int PT_W       = AXES * COORD_W;

    localparam int S_W  = FRAC_W + 1;
    localparam int T2_W = 2 * FRAC_W;
    localparam int S2_W = 2 * FRAC_W + 1;
    localparam int T3_W = 3 * FRAC_W;
    localparam int S3_W = 3 * FRAC_W + 1;

    localparam int WQ_W   = 53;
    localparam int WGT_W  = 28;
    localparam int PROD_W = COORD_W + WGT_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam int VEL_WSH = 8;
    localparam int POS_WSH = 24;
    localparam int PV_SH   = 24;
    localparam int ACC_SH  = 16;

    // divide by three: multiply by the reciprocal, exact for H_W-bit inputs
    localparam int H_W     = 37;
    localparam int H_LO_W  = 19;
    localparam int H_HI_W  = H_W - H_LO_W;
    localparam int RCP3_W  = 37;
    localparam int RCP3_SH = 38;
    localparam logic [RCP3_W-1:0] RCP3 = 37'd91625968982;
    localparam int PL_W    = H_LO_W + RCP3_W;
    localparam int PH_W    = H_HI_W + RCP3_W;
    localparam int QS_W    = PH_W + H_LO_W;
    localparam int Q_W     = 35;

    localparam int STEP1_W    = 26;
    localparam int STEP_W     = 36;
    localparam int STEP_LO_W  = 18;
    localparam int QP_W       = Q_W + STEP_LO_W;
    localparam int P_W        = Q_W + STEP_W;
    localparam int R_W        = P_W - FRAC_W;
    localparam int OUT_W      = 32;
    localparam int STEP_RESET = 65536;

    localparam int PIPE_DEPTH = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic signed [WQ_W-1:0] Q32_ONE = 53'sd4294967296;
    localparam logic signed [WQ_W-1:0] Q48_ONE = 53'sd281474976710656;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_INV_STEP    = 2'd1,
        CFG_INV_STEP_SQ = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_EVAL  = 1'b1
    } func_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WGT_W-1:0]   wgt_t;

endpackage

// ===== rtl/core/cubic_bspline_evaluator_unit.sv =====
// Uniform cubic B-spline evaluator: banked point store and evaluation pipeline
// Takes one item per clock while the output is not held. A point write lands
// in the store on its transfer and gives no result; an evaluate item gives one
// result through twelve register stages (store read, basis powers, weights,
// products, a two-level adder tree, rounding, divide by six through a split
// reciprocal multiply, step scaling and saturation). The four store banks
// each serve one of the four control points of a segment in the same cycle.
// When the result at the output is held, the whole pipeline holds and the
// input stalls. Configuration writes are taken at once (ready is always high).
`timescale 1ns / 1ps
`include "cubic_bspline_evaluator_unit_macros.svh"

module cubic_bspline_evaluator_unit
    import cbspl_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic        [IDX_W-1:0]      point_index,
    input  logic signed [COORD_W-1:0]    point_x,
    input  logic signed [COORD_W-1:0]    point_y,
    input  logic signed [COORD_W-1:0]    point_z,
    input  logic        [U_W-1:0]        param_u,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         eval_valid,
    output logic signed [OUT_W-1:0]      pos_x,
    output logic signed [OUT_W-1:0]      pos_y,
    output logic signed [OUT_W-1:0]      pos_z,
    output logic signed [OUT_W-1:0]      vel_x,
    output logic signed [OUT_W-1:0]      vel_y,
    output logic signed [OUT_W-1:0]      vel_z,
    output logic signed [OUT_W-1:0]      acc_x,
    output logic signed [OUT_W-1:0]      acc_y,
    output logic signed [OUT_W-1:0]      acc_z,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    function automatic wgt_t round_shift(input logic signed [WQ_W-1:0] v, input int sh);
        logic [WQ_W-1:0] mag;
        logic [WQ_W-1:0] rnd;
        mag = v[WQ_W-1] ? WQ_W'(-v) : WQ_W'(v);
        rnd = (mag + (WQ_W'(1) << (sh - 1))) >> sh;
        return v[WQ_W-1] ? WGT_W'(-rnd) : WGT_W'(rnd);
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(input logic neg, input logic [R_W-1:0] mag);
        logic [R_W-1:0] lim;
        lim = neg ? (R_W'(1) << (OUT_W - 1)) : ((R_W'(1) << (OUT_W - 1)) - R_W'(1));
        if (mag > lim)
        begin
            return neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return neg ? OUT_W'(-mag) : OUT_W'(mag);
    endfunction

    // configuration
    logic [CNT_W-1:0]   point_count_reg;
    logic [STEP1_W-1:0] inv_step_reg;
    logic [STEP_W-1:0]  inv_step_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            inv_step_reg    <= STEP1_W'(STEP_RESET);
            inv_step_sq_reg <= STEP_W'(STEP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POINT_COUNT: point_count_reg <= cfg_data[CNT_W-1:0];
                CFG_INV_STEP:    inv_step_reg    <= cfg_data[STEP1_W-1:0];
                CFG_INV_STEP_SQ: inv_step_sq_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: everything holds while the output waits
    logic                  advance;
    logic                  in_acc;
    logic                  pt_write;
    logic                  pt_eval;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] ok_reg;

    assign advance   = !(vld_reg[PIPE_DEPTH-1] && out_stall);
    assign in_stall  = !advance;
    assign in_acc    = in_valid && !in_stall;
    assign pt_write  = in_acc && (func_t'(func) == FUNC_WRITE);
    assign pt_eval   = in_acc && (func_t'(func) == FUNC_EVAL);

    // segment selection
    logic [CNT_W-1:0]  cnt;
    logic              cnt_ok;
    logic [IDX_W-1:0]  seg_lim;
    logic [U_W-1:0]    u_max;
    logic [U_W-1:0]    u_clamp;
    logic [IDX_W-1:0]  seg_k;
    logic [FRAC_W-1:0] frac_t;

    assign cnt     = (point_count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : point_count_reg;
    assign cnt_ok  = (cnt >= CNT_W'(TAPS));
    assign seg_lim = IDX_W'(cnt - CNT_W'(TAPS - 1));
    assign u_max   = {seg_lim, {FRAC_W{1'b0}}} - U_W'(1);
    assign u_clamp = (param_u > u_max) ? u_max : param_u;
    assign seg_k   = u_clamp[U_W-1:FRAC_W];
    assign frac_t  = u_clamp[FRAC_W-1:0];

    // banked point store: point n lives in bank n mod 4
    logic [BANKS-1:0] bank_we;
    logic [PT_W-1:0]  bank_rdata [BANKS];

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [BANK_SEL_W-1:0] tap_j;
        logic [IDX_W-1:0]      rd_idx;

        assign tap_j      = BANK_SEL_W'(b) - seg_k[BANK_SEL_W-1:0];
        assign rd_idx     = seg_k + IDX_W'(tap_j);
        assign bank_we[b] = pt_write && (point_index[BANK_SEL_W-1:0] == BANK_SEL_W'(b));

        cbspl_ram #(
            .WIDTH (PT_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (point_index[IDX_W-1:BANK_SEL_W]),
            .wdata ({point_z, point_y, point_x}),
            .re    (advance),
            .raddr (rd_idx[IDX_W-1:BANK_SEL_W]),
            .rdata (bank_rdata[b])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ok_reg  <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], pt_eval};
            ok_reg  <= {ok_reg[PIPE_DEPTH-2:0], cnt_ok};
        end
    end

    // stage registers
    logic [FRAC_W-1:0]     s1_t_reg;
    logic [BANK_SEL_W-1:0] s1_rot_reg;
    logic [S_W-1:0]        s1_s;
    coord_t                rot_coord [TAPS][AXES];

    logic [FRAC_W-1:0]     s2_t_reg;
    logic [S_W-1:0]        s2_s_reg;
    logic [T2_W-1:0]       s2_t2_reg;
    logic [S2_W-1:0]       s2_s2_reg;
    coord_t                s2_coord_reg [TAPS][AXES];

    logic [FRAC_W-1:0]     s3_t_reg;
    logic [T2_W-1:0]       s3_t2_reg;
    logic [T3_W-1:0]       s3_t3_reg;
    logic [S3_W-1:0]       s3_s3_reg;
    wgt_t                  s3_wv_reg [TAPS];
    wgt_t                  s3_wa_reg [TAPS];
    coord_t                s3_coord_reg [TAPS][AXES];

    wgt_t                  s4_w_reg [KINDS][TAPS];
    coord_t                s4_coord_reg [TAPS][AXES];

    logic signed [PROD_W-1:0] s5_prod_reg [KINDS][AXES][TAPS];
    logic signed [ACC_W-1:0]  s6_pair_reg [KINDS][AXES][2];
    logic signed [ACC_W-1:0]  s7_sum_reg  [KINDS][AXES];

    logic [H_W-1:0]        s8_h_reg   [KINDS][AXES];
    logic                  s8_neg_reg [KINDS][AXES];
    logic [PL_W-1:0]       s9_pl_reg  [KINDS][AXES];
    logic [PH_W-1:0]       s9_ph_reg  [KINDS][AXES];
    logic                  s9_neg_reg [KINDS][AXES];
    logic [Q_W-1:0]        s10_q_reg  [KINDS][AXES];
    logic                  s10_neg_reg [KINDS][AXES];
    logic [OUT_W-1:0]      s11_pos_reg [AXES];
    logic [QP_W-1:0]       s11_ql_reg [KINDS-1][AXES];
    logic [QP_W-1:0]       s11_qh_reg [KINDS-1][AXES];
    logic                  s11_neg_reg [KINDS-1][AXES];
    logic [OUT_W-1:0]      s12_out_reg [KINDS][AXES];

    // stage 2 inputs: order the bank outputs by tap
    assign s1_s = S_W'(1 << FRAC_W) - S_W'(s1_t_reg);

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                rot_coord[i][a] =
                    bank_rdata[BANK_SEL_W'(s1_rot_reg + BANK_SEL_W'(i))][a*COORD_W +: COORD_W];
            end
        end
    end

    // derivative weights from t, s and their squares
    logic signed [WQ_W-1:0] tq2, sq2, t2q2, s2q2;
    logic signed [WQ_W-1:0] wvq [TAPS];
    logic signed [WQ_W-1:0] waq [TAPS];

    always_comb
    begin
        tq2  = WQ_W'(s2_t_reg);
        sq2  = WQ_W'(s2_s_reg);
        t2q2 = WQ_W'(s2_t2_reg);
        s2q2 = WQ_W'(s2_s2_reg);
        wvq[0] = -(s2q2 * 3);
        wvq[1] = t2q2 * 9 - tq2 * 12 * 65536;
        wvq[2] = 3 * Q32_ONE + tq2 * 6 * 65536 - t2q2 * 9;
        wvq[3] = t2q2 * 3;
        waq[0] = sq2 * 6;
        waq[1] = tq2 * 18 - 12 * 65536;
        waq[2] = 6 * 65536 - tq2 * 18;
        waq[3] = tq2 * 6;
    end

    // position weights from the cubes
    logic signed [WQ_W-1:0] tq3, t2q3, t3q3, s3q3;
    logic signed [WQ_W-1:0] wpq [TAPS];

    always_comb
    begin
        tq3  = WQ_W'(s3_t_reg);
        t2q3 = WQ_W'(s3_t2_reg);
        t3q3 = WQ_W'(s3_t3_reg);
        s3q3 = WQ_W'(s3_s3_reg);
        wpq[0] = s3q3;
        wpq[1] = t3q3 * 3 - t2q3 * 6 * 65536 + 4 * Q48_ONE;
        wpq[2] = Q48_ONE + tq3 * 3 * Q32_ONE + t2q3 * 3 * 65536 - t3q3 * 3;
        wpq[3] = t3q3;
    end

    // rounding to the nearest sixth: magnitude, half-step, drop fraction
    logic [ACC_W-1:0] mag8 [KINDS][AXES];
    logic [ACC_W-1:0] rnd8 [KINDS][AXES];

    always_comb
    begin
        for (int k = 0; k < KINDS; k++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                mag8[k][a] = s7_sum_reg[k][a][ACC_W-1] ? ACC_W'(-s7_sum_reg[k][a])
                                                       : ACC_W'(s7_sum_reg[k][a]);
                if (k == KIND_ACC)
                begin
                    rnd8[k][a] = (mag8[k][a] + (ACC_W'(3) << ACC_SH)) >> ACC_SH;
                end
                else
                begin
                    rnd8[k][a] = (mag8[k][a] + (ACC_W'(3) << PV_SH)) >> PV_SH;
                end
            end
        end
    end

    logic [QS_W-1:0]   qs10 [KINDS][AXES];
    logic [STEP_W-1:0] step11 [KINDS-1];
    logic [P_W-1:0]    p12 [KINDS-1][AXES];
    logic [R_W-1:0]    r12 [KINDS-1][AXES];

    always_comb
    begin
        for (int k = 0; k < KINDS; k++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                qs10[k][a] = {s9_ph_reg[k][a], {H_LO_W{1'b0}}} + QS_W'(s9_pl_reg[k][a]);
            end
        end
        step11[0] = STEP_W'(inv_step_reg);
        step11[1] = inv_step_sq_reg;
        for (int k = 0; k < KINDS - 1; k++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                p12[k][a] = {s11_qh_reg[k][a], {STEP_LO_W{1'b0}}} + P_W'(s11_ql_reg[k][a]);
                r12[k][a] = R_W'((p12[k][a] + (P_W'(1) << (FRAC_W - 1))) >> FRAC_W);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_t_reg   <= frac_t;
            s1_rot_reg <= seg_k[BANK_SEL_W-1:0];

            s2_t_reg     <= s1_t_reg;
            s2_s_reg     <= s1_s;
            s2_t2_reg    <= s1_t_reg * s1_t_reg;
            s2_s2_reg    <= s1_s * s1_s;
            s2_coord_reg <= rot_coord;

            s3_t_reg     <= s2_t_reg;
            s3_t2_reg    <= s2_t2_reg;
            s3_t3_reg    <= s2_t2_reg * s2_t_reg;
            s3_s3_reg    <= s2_s2_reg * s2_s_reg;
            s3_coord_reg <= s2_coord_reg;
            for (int i = 0; i < TAPS; i++)
            begin
                s3_wv_reg[i] <= round_shift(wvq[i], VEL_WSH);
                s3_wa_reg[i] <= WGT_W'(waq[i]);
            end

            s4_coord_reg <= s3_coord_reg;
            for (int i = 0; i < TAPS; i++)
            begin
                s4_w_reg[KIND_POS][i] <= round_shift(wpq[i], POS_WSH);
                s4_w_reg[KIND_VEL][i] <= s3_wv_reg[i];
                s4_w_reg[KIND_ACC][i] <= s3_wa_reg[i];
            end

            for (int k = 0; k < KINDS; k++)
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    for (int i = 0; i < TAPS; i++)
                    begin
                        s5_prod_reg[k][a][i] <= s4_coord_reg[i][a] * s4_w_reg[k][i];
                    end
                    s6_pair_reg[k][a][0] <= s5_prod_reg[k][a][0] + s5_prod_reg[k][a][1];
                    s6_pair_reg[k][a][1] <= s5_prod_reg[k][a][2] + s5_prod_reg[k][a][3];
                    s7_sum_reg[k][a]     <= s6_pair_reg[k][a][0] + s6_pair_reg[k][a][1];

                    s8_h_reg[k][a]   <= H_W'(rnd8[k][a] >> 1);
                    s8_neg_reg[k][a] <= s7_sum_reg[k][a][ACC_W-1];

                    s9_pl_reg[k][a]  <= s8_h_reg[k][a][H_LO_W-1:0] * RCP3;
                    s9_ph_reg[k][a]  <= s8_h_reg[k][a][H_W-1:H_LO_W] * RCP3;
                    s9_neg_reg[k][a] <= s8_neg_reg[k][a];

                    s10_q_reg[k][a]   <= qs10[k][a][RCP3_SH +: Q_W];
                    s10_neg_reg[k][a] <= s9_neg_reg[k][a];
                end
            end

            for (int a = 0; a < AXES; a++)
            begin
                s11_pos_reg[a] <= sat_out(s10_neg_reg[KIND_POS][a],
                                          R_W'(s10_q_reg[KIND_POS][a]));
                for (int k = 0; k < KINDS - 1; k++)
                begin
                    s11_ql_reg[k][a]  <= s10_q_reg[k+1][a] * step11[k][STEP_LO_W-1:0];
                    s11_qh_reg[k][a]  <= s10_q_reg[k+1][a] * step11[k][STEP_W-1:STEP_LO_W];
                    s11_neg_reg[k][a] <= s10_neg_reg[k+1][a];
                end
            end

            // fewer than four points: all results zero
            for (int a = 0; a < AXES; a++)
            begin
                s12_out_reg[KIND_POS][a] <= ok_reg[PIPE_DEPTH-2] ? s11_pos_reg[a] : '0;
                for (int k = 0; k < KINDS - 1; k++)
                begin
                    s12_out_reg[k+1][a] <= ok_reg[PIPE_DEPTH-2]
                                         ? sat_out(s11_neg_reg[k][a], r12[k][a]) : '0;
                end
            end
        end
    end

    assign out_valid  = vld_reg[PIPE_DEPTH-1];
    assign eval_valid = ok_reg[PIPE_DEPTH-1];
    assign pos_x = s12_out_reg[KIND_POS][0];
    assign pos_y = s12_out_reg[KIND_POS][1];
    assign pos_z = s12_out_reg[KIND_POS][2];
    assign vel_x = s12_out_reg[KIND_VEL][0];
    assign vel_y = s12_out_reg[KIND_VEL][1];
    assign vel_z = s12_out_reg[KIND_VEL][2];
    assign acc_x = s12_out_reg[KIND_ACC][0];
    assign acc_y = s12_out_reg[KIND_ACC][1];
    assign acc_z = s12_out_reg[KIND_ACC][2];

    `CBSPL_ASSERT_NEXT(a_eval_enters, clk, rst_n, in_valid && !in_stall, vld_reg[0] == ($past(func) == FUNC_EVAL), "stage one valid does not follow the accepted item")
    `CBSPL_ASSERT_SAME(a_seg_in_range, clk, rst_n, pt_eval && cnt_ok, ({1'b0, seg_k} + CNT_W'(TAPS - 1)) < cnt, "segment reaches past the last point")
    `CBSPL_ASSERT_SAME(a_invalid_zero, clk, rst_n, out_valid && !eval_valid, pos_x == '0 && pos_y == '0 && pos_z == '0 && vel_x == '0 && vel_y == '0 && vel_z == '0 && acc_x == '0 && acc_y == '0 && acc_z == '0, "invalid result carries nonzero data")
    `CBSPL_ASSERT_NEXT(a_pipe_holds, clk, rst_n, in_stall, $stable(vld_reg), "pipeline moved while held")

endmodule

// ===== rtl/core/cbspl_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module cbspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
